@@ rtl/core/hsfp_pkg.sv @@
// ----------------------------------------------------------------------------
// hsfp_pkg
// Types and constants shared by the hashed star field point pipeline.
// ----------------------------------------------------------------------------
package hsfp_pkg;

    localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;

    // radians Q62 of pi over the number of Q16 half steps in 180 degrees
    localparam logic [63:0] ANGLE_SCALE = 64'hC90FDAA22168C234 / 64'd23592960;
    localparam logic [19:0] ANGLE_HI    = ANGLE_SCALE[39:20];
    localparam logic [19:0] ANGLE_LO    = ANGLE_SCALE[19:0];

    localparam logic [22:0] ELEV_MAX    = 23'd5898240;
    localparam logic [8:0]  AZ_SCALE    = 9'd360;

    localparam int SEARCH_STEPS = 23;
    localparam int SINE_TERMS   = 12;
    localparam int STEP_STAGES  = 2 * SINE_TERMS + 4;

    // exact floor division of a 32-bit value by (2n)(2n+1)
    localparam int DIV_SHIFT [SINE_TERMS] = '{35, 37, 38, 39, 39, 40, 40, 41, 41, 41, 41, 42};
    localparam logic [32:0] DIV_RECIP [SINE_TERMS] = '{
        33'(((65'd1 << 35) + 65'd5)   / 65'd6),
        33'(((65'd1 << 37) + 65'd19)  / 65'd20),
        33'(((65'd1 << 38) + 65'd41)  / 65'd42),
        33'(((65'd1 << 39) + 65'd71)  / 65'd72),
        33'(((65'd1 << 39) + 65'd109) / 65'd110),
        33'(((65'd1 << 40) + 65'd155) / 65'd156),
        33'(((65'd1 << 40) + 65'd209) / 65'd210),
        33'(((65'd1 << 41) + 65'd271) / 65'd272),
        33'(((65'd1 << 41) + 65'd341) / 65'd342),
        33'(((65'd1 << 41) + 65'd419) / 65'd420),
        33'(((65'd1 << 41) + 65'd505) / 65'd506),
        33'(((65'd1 << 42) + 65'd599) / 65'd600)
    };

    typedef enum logic [1:0] {
        CFG_SEED  = 2'd0,
        CFG_COUNT = 2'd1,
        CFG_LIMIT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        in_field;
        logic [24:0] azimuth;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic        neg;
        logic [31:0] a;
        logic [22:0] lo;
        logic [22:0] hi;
        logic [22:0] m;
        logic [43:0] pph;
        logic [43:0] ppl;
        logic [30:0] th;
        logic [31:0] th2;
        logic [31:0] t;
        logic [33:0] s;
    } t_srec;

endpackage

@@ rtl/core/hsfp_asin.sv @@
// ----------------------------------------------------------------------------
// hsfp_asin
// Pipelined binary search for the rounded arcsine in Q16 degrees, one search
// step per group of stages, fixed-point Taylor sine in each step.
// ----------------------------------------------------------------------------
module hsfp_asin (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  hsfp_pkg::t_srec i_rec,
    output logic           o_valid,
    output hsfp_pkg::t_srec o_rec
);
    import hsfp_pkg::*;

    localparam int TOTAL = SEARCH_STEPS * STEP_STAGES;

    t_srec r_pipe [TOTAL];
    logic  r_vld  [TOTAL];

    for (genvar k = 0; k < TOTAL; k++) begin : g_stg
        localparam int J = k % STEP_STAGES;
        t_srec w_prev;
        logic  w_pv;
        t_srec n_rec;

        if (k == 0) begin : g_first
            assign w_prev = i_rec;
            assign w_pv   = i_valid;
        end else begin : g_next
            assign w_prev = r_pipe[k-1];
            assign w_pv   = r_vld[k-1];
        end

        if (J == 0) begin : g_setup
            always_comb begin
                logic [23:0] m_sum;
                logic [23:0] x;
                n_rec     = w_prev;
                m_sum     = {1'b0, w_prev.lo} + {1'b0, w_prev.hi} + 24'd1;
                n_rec.m   = m_sum[23:1];
                x         = {m_sum[23:1], 1'b0} - 24'd1;
                n_rec.pph = 44'(x) * 44'(ANGLE_HI);
                n_rec.ppl = 44'(x) * 44'(ANGLE_LO);
            end
        end else if (J == 1) begin : g_angle
            always_comb begin
                logic [63:0] sum;
                n_rec    = w_prev;
                sum      = {w_prev.pph, 20'b0} + {20'b0, w_prev.ppl};
                n_rec.th = sum[62:32];
            end
        end else if (J == 2) begin : g_square
            always_comb begin
                logic [61:0] sq;
                n_rec     = w_prev;
                sq        = 62'(w_prev.th) * 62'(w_prev.th);
                n_rec.th2 = sq[61:30];
                n_rec.t   = {1'b0, w_prev.th};
                n_rec.s   = {3'b0, w_prev.th};
            end
        end else if (J == STEP_STAGES - 1) begin : g_decide
            always_comb begin
                logic [33:0] s_fin;
                logic [33:0] dbl;
                logic        pred;
                n_rec = w_prev;
                s_fin = w_prev.s + {2'b0, w_prev.t};
                dbl   = {s_fin[32:0], 1'b0};
                pred  = s_fin[33] || (dbl <= {2'b0, w_prev.a});
                n_rec.s = s_fin;
                if (w_prev.lo < w_prev.hi) begin
                    if (pred) begin
                        n_rec.lo = w_prev.m;
                    end else begin
                        n_rec.hi = w_prev.m - 23'd1;
                    end
                end
            end
        end else begin : g_term
            localparam int N_TERM = (J - 3) / 2 + 1;
            if (((J - 3) % 2) == 0) begin : g_mul
                always_comb begin
                    logic [63:0] prod;
                    n_rec = w_prev;
                    if (N_TERM > 1) begin
                        if (((N_TERM - 1) % 2) == 1) begin
                            n_rec.s = w_prev.s - {2'b0, w_prev.t};
                        end else begin
                            n_rec.s = w_prev.s + {2'b0, w_prev.t};
                        end
                    end
                    prod    = 64'(w_prev.t) * 64'(w_prev.th2);
                    n_rec.t = prod[61:30];
                end
            end else begin : g_div
                always_comb begin
                    logic [64:0] prod;
                    logic [64:0] quo;
                    n_rec   = w_prev;
                    prod    = 65'(w_prev.t) * 65'(DIV_RECIP[N_TERM-1]);
                    quo     = prod >> DIV_SHIFT[N_TERM-1];
                    n_rec.t = quo[31:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pipe[k] <= n_rec;
            end
        end
    end

    assign o_valid = r_vld[TOTAL-1];
    assign o_rec   = r_pipe[TOTAL-1];

endmodule

@@ rtl/core/hashed_star_field_point.sv @@
// ----------------------------------------------------------------------------
// hashed_star_field_point
// Sky position of one star of a hashed star field: two splitmix64 hashes,
// azimuth in Q16 degrees and uniform-sphere elevation by arcsine search.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  in       | to core   | i_valid / o_stall  | i_star_index
//  out      | from core | o_valid / i_stall  | o_in_field, o_azimuth_q16,
//           |           |                    | o_elevation_q16
//  cfg      | to core   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One transfer per cycle while the output is not stalled; the arcsine runs
// 23 search steps of 28 stages each.
// Synchronous active-low reset clears all valid bits and the configuration registers.
// A stalled output freezes the pipeline; the input register still takes one
// transfer while empty.
// ----------------------------------------------------------------------------
module hashed_star_field_point #(
    parameter int INDEX_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [INDEX_BITS-1:0] i_star_index,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_in_field,
    output logic [24:0]           o_azimuth_q16,
    output logic signed [23:0]    o_elevation_q16,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [63:0]           i_cfg_data
);
    import hsfp_pkg::*;

    logic [63:0] r_seed;
    logic [15:0] r_count;
    logic [15:0] r_limit;

    logic                  adv;
    logic                  r_v0;
    logic [INDEX_BITS-1:0] r_idx;

    logic        r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9;
    logic        r_f1, r_f2, r_f3, r_f4, r_f5, r_f6, r_f7, r_f8;
    logic [63:0] r_pl, r_ph;
    logic [63:0] r_ig;
    logic [63:0] r_hv  [2];
    logic [63:0] r_p0  [2];
    logic [31:0] r_p1  [2];
    logic [31:0] r_p2  [2];
    logic [63:0] r_z   [2];
    logic [63:0] r_q0  [2];
    logic [31:0] r_q1  [2];
    logic [31:0] r_q2  [2];
    logic [63:0] r_z2  [2];
    logic [63:0] r_h   [2];
    t_side       r_side9;
    logic        r_neg9;
    logic [31:0] r_a9;

    t_srec       w_in_rec;
    logic        w_as_v;
    t_srec       w_as_rec;

    logic        r_out_v;
    logic        r_out_f;
    logic [24:0] r_out_az;
    logic [23:0] r_out_el;
    logic [15:0] w_bound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= '0;
            r_count <= '0;
            r_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEED:  r_seed  <= i_cfg_data;
                CFG_COUNT: r_count <= i_cfg_data[15:0];
                CFG_LIMIT: r_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign adv     = !r_out_v || !i_stall;
    assign o_stall = r_v0 && !adv;
    assign w_bound = (r_count < r_limit) ? r_count : r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (!r_v0 || adv) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_v0 || adv) begin
            r_idx <= i_star_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9} <= '0;
        end else if (adv) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9} <=
                {r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [63:0] y;
        logic [63:0] w;
        logic [31:0] top_b;
        logic [40:0] az;
        if (adv) begin
            r_f1 <= 32'(r_idx) < 32'(w_bound);
            r_pl <= 64'(r_idx) * 64'(GOLDEN_STEP[31:0]);
            r_ph <= 64'(r_idx) * 64'(GOLDEN_STEP[63:32]);

            r_f2 <= r_f1;
            r_ig <= r_pl + {r_ph[31:0], 32'b0};

            r_f3     <= r_f2;
            r_hv[0]  <= r_seed + {r_ig[62:0], 1'b0};
            r_hv[1]  <= r_seed + {r_ig[62:0], 1'b0} + GOLDEN_STEP;

            r_f4 <= r_f3;
            r_f5 <= r_f4;
            r_f6 <= r_f5;
            r_f7 <= r_f6;
            r_f8 <= r_f7;
            for (int i = 0; i < 2; i++) begin
                y       = r_hv[i] ^ (r_hv[i] >> 30);
                r_p0[i] <= 64'(y[31:0]) * 64'(MIX_MUL_A[31:0]);
                r_p1[i] <= 32'(y[31:0] * MIX_MUL_A[63:32]);
                r_p2[i] <= 32'(y[63:32] * MIX_MUL_A[31:0]);

                r_z[i]  <= r_p0[i] + {r_p1[i] + r_p2[i], 32'b0};

                w       = r_z[i] ^ (r_z[i] >> 27);
                r_q0[i] <= 64'(w[31:0]) * 64'(MIX_MUL_B[31:0]);
                r_q1[i] <= 32'(w[31:0] * MIX_MUL_B[63:32]);
                r_q2[i] <= 32'(w[63:32] * MIX_MUL_B[31:0]);

                r_z2[i] <= r_q0[i] + {r_q1[i] + r_q2[i], 32'b0};

                r_h[i]  <= r_z2[i] ^ (r_z2[i] >> 31);
            end

            az                   = 41'(r_h[0][63:32]) * 41'(AZ_SCALE);
            top_b                = r_h[1][63:32];
            r_side9.in_field     <= r_f8;
            r_side9.azimuth      <= az[40:16];
            r_neg9               <= !top_b[31];
            r_a9                 <= top_b[31] ? {1'b0, top_b[30:0]} : (32'h8000_0000 - top_b);
        end
    end

    always_comb begin
        w_in_rec      = '0;
        w_in_rec.side = r_side9;
        w_in_rec.neg  = r_neg9;
        w_in_rec.a    = r_a9;
        w_in_rec.lo   = '0;
        w_in_rec.hi   = ELEV_MAX;
    end

    hsfp_asin u_asin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_v9),
        .i_rec   (w_in_rec),
        .o_valid (w_as_v),
        .o_rec   (w_as_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= w_as_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_f  <= w_as_rec.side.in_field;
            r_out_az <= w_as_rec.side.azimuth;
            r_out_el <= w_as_rec.neg ? (24'd0 - {1'b0, w_as_rec.lo}) : {1'b0, w_as_rec.lo};
        end
    end

    assign o_valid         = r_out_v;
    assign o_in_field      = r_out_f;
    assign o_azimuth_q16   = r_out_az;
    assign o_elevation_q16 = $signed(r_out_el);

endmodule

@@ rtl/core/hsfp_chk.sv @@
// ----------------------------------------------------------------------------
// hsfp_chk
// Port-level checks for hashed_star_field_point, bound to the top level.
// ----------------------------------------------------------------------------
module hsfp_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_in_field,
    input logic [24:0]        o_azimuth_q16,
    input logic signed [23:0] o_elevation_q16
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_azimuth_q16)
            && $stable(o_elevation_q16) && $stable(o_in_field))
        else $error("result changed while stalled");

    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

    a_az_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_azimuth_q16 <= 25'd23592959)
        else $error("azimuth out of range");

    a_el_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_elevation_q16 <= 24'sd5898240) && (o_elevation_q16 >= -24'sd5898240))
        else $error("elevation out of range");

endmodule

bind hashed_star_field_point hsfp_chk u_hsfp_chk (.*);
